// File: rtl/rctu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctu_pkg - shared types and constants of the CSR and trap unit
// Codes of the item fields, CSR addresses, write masks and the state record.
// ----------------------------------------------------------------------------
package rctu_pkg;

  // item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;

  // write operations
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // retire event codes
  localparam logic [2:0] EV_ECALL    = 3'd0;
  localparam logic [2:0] EV_INST_PF  = 3'd1;
  localparam logic [2:0] EV_LOAD_PF  = 3'd2;
  localparam logic [2:0] EV_STORE_PF = 3'd3;
  localparam logic [2:0] EV_ILLEGAL  = 3'd4;
  localparam logic [2:0] EV_MRET     = 3'd5;
  localparam logic [2:0] EV_SRET     = 3'd6;
  localparam logic [2:0] EV_IRQ_ONLY = 3'd7;

  // redirect codes
  localparam logic [2:0] REDIR_NONE   = 3'd0;
  localparam logic [2:0] REDIR_M_TRAP = 3'd1;
  localparam logic [2:0] REDIR_S_TRAP = 3'd2;
  localparam logic [2:0] REDIR_MRET   = 3'd3;
  localparam logic [2:0] REDIR_SRET   = 3'd4;

  // privilege levels
  localparam logic [1:0] PRIV_U  = 2'd0;
  localparam logic [1:0] PRIV_S  = 2'd1;
  localparam logic [1:0] PRIV_RS = 2'd2;
  localparam logic [1:0] PRIV_M  = 2'd3;

  // CSR addresses
  localparam logic [11:0] CSR_SSTATUS   = 12'h100;
  localparam logic [11:0] CSR_SIE       = 12'h104;
  localparam logic [11:0] CSR_STVEC     = 12'h105;
  localparam logic [11:0] CSR_SEPC      = 12'h141;
  localparam logic [11:0] CSR_SCAUSE    = 12'h142;
  localparam logic [11:0] CSR_STVAL     = 12'h143;
  localparam logic [11:0] CSR_SIP       = 12'h144;
  localparam logic [11:0] CSR_MSTATUS   = 12'h300;
  localparam logic [11:0] CSR_MISA      = 12'h301;
  localparam logic [11:0] CSR_EXC_DELEG = 12'h302;
  localparam logic [11:0] CSR_MIDELEG   = 12'h303;
  localparam logic [11:0] CSR_MIE       = 12'h304;
  localparam logic [11:0] CSR_MTVEC     = 12'h305;
  localparam logic [11:0] CSR_MEPC      = 12'h341;
  localparam logic [11:0] CSR_MCAUSE    = 12'h342;
  localparam logic [11:0] CSR_MTVAL     = 12'h343;
  localparam logic [11:0] CSR_MIP       = 12'h344;

  localparam logic [31:0] MISA_RESET = 32'h4014_1101;

  // alias masks
  localparam logic [31:0] S_KEEP_MASK   = 32'hffff_fccc;
  localparam logic [31:0] S_WRITE_MASK  = 32'h0000_0333;
  localparam logic [31:0] M_KEEP_MASK   = 32'hffff_f444;
  localparam logic [31:0] M_WRITE_MASK  = 32'h0000_0bbb;
  localparam logic [31:0] SSTATUS_KEEP  = 32'h7ff2_1ecc;
  localparam logic [31:0] MSTATUS_KEEP  = 32'h7f80_0644;
  localparam logic [31:0] TVEC_BASE     = 32'hffff_fffc;

  // payload of an input word other than the address
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  write_op;
    logic [31:0] write_data;
    logic [2:0]  event_code;
    logic [31:0] pc;
    logic [31:0] trap_value;
  } item_t;

  // result word
  typedef struct packed {
    logic [31:0] read_data;
    logic [2:0]  redirect;
    logic [31:0] target_pc;
    logic [1:0]  current_privilege;
  } result_t;

  // architectural state held in flip-flops; mstatus and sstatus share one
  // register, as do mie/sie and mip/sip
  typedef struct packed {
    logic [1:0]  priv;
    logic [31:0] status;
    logic [31:0] ie;
    logic [31:0] ip;
    logic [31:0] medeleg;
    logic [31:0] mideleg;
    logic [31:0] mtvec;
    logic [31:0] stvec;
    logic [31:0] mepc;
    logic [31:0] sepc;
    logic [31:0] mcause;
    logic [31:0] scause;
    logic [31:0] mtval;
    logic [31:0] stval;
  } csr_state_t;

  // write request towards the plain CSR memory
  typedef struct packed {
    logic        we;
    logic [31:0] data;
  } ram_wr_t;

endpackage

// File: rtl/rctu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctu_if - handshake channels of the CSR and trap unit
// Input channel (access or retire event) and result channel.
// ----------------------------------------------------------------------------
interface rctu_in_if #(
  parameter int ADDR_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [ADDR_BITS-1:0] csr_index;
  logic [1:0]           write_op;
  logic [31:0]          write_data;
  logic [2:0]           event_code;
  logic [31:0]          pc;
  logic [31:0]          trap_value;

  modport source (
    output valid, kind, csr_index, write_op, write_data, event_code, pc, trap_value,
    input  ready
  );
  modport sink (
    input  valid, kind, csr_index, write_op, write_data, event_code, pc, trap_value,
    output ready
  );
endinterface

interface rctu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  redirect;
  logic [31:0] target_pc;
  logic [1:0]  current_privilege;

  modport source (
    output valid, read_data, redirect, target_pc, current_privilege,
    input  ready
  );
  modport sink (
    input  valid, read_data, redirect, target_pc, current_privilege,
    output ready
  );
endinterface

// File: rtl/rctu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctu_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns the old data.
// ----------------------------------------------------------------------------
module rctu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: rtl/rctu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rctu_exec - access and trap logic of the CSR unit
// Works out the read value, the CSR update and the redirect of one word.
// ----------------------------------------------------------------------------
module rctu_exec #(
  parameter int ADDR_BITS = 12
) (
  input  logic [ADDR_BITS-1:0] csr_index,
  input  rctu_pkg::item_t      item,
  input  rctu_pkg::csr_state_t st,
  input  logic [31:0]          ram_rdata,
  output rctu_pkg::csr_state_t st_nxt,
  output rctu_pkg::ram_wr_t    ram_wr,
  output rctu_pkg::result_t    result
);

  localparam logic [4:0] SEL_RAM      = 5'd0;
  localparam logic [4:0] SEL_SSTATUS  = 5'd1;
  localparam logic [4:0] SEL_MSTATUS  = 5'd2;
  localparam logic [4:0] SEL_SIE      = 5'd3;
  localparam logic [4:0] SEL_MIE      = 5'd4;
  localparam logic [4:0] SEL_SIP      = 5'd5;
  localparam logic [4:0] SEL_MIP      = 5'd6;
  localparam logic [4:0] SEL_MEDELEG  = 5'd7;
  localparam logic [4:0] SEL_MIDELEG  = 5'd8;
  localparam logic [4:0] SEL_MTVEC    = 5'd9;
  localparam logic [4:0] SEL_STVEC    = 5'd10;
  localparam logic [4:0] SEL_MEPC     = 5'd11;
  localparam logic [4:0] SEL_SEPC     = 5'd12;
  localparam logic [4:0] SEL_MCAUSE   = 5'd13;
  localparam logic [4:0] SEL_SCAUSE   = 5'd14;
  localparam logic [4:0] SEL_MTVAL    = 5'd15;
  localparam logic [4:0] SEL_STVAL    = 5'd16;

  function automatic logic [31:0] m_stack(input logic [31:0] s, input logic [1:0] p);
    logic [31:0] r;
    r = s & ~32'h0000_1888;
    r[12:11] = p;
    r[7] = s[3];
    return r;
  endfunction

  function automatic logic [31:0] s_stack(input logic [31:0] s, input logic [1:0] p);
    logic [31:0] r;
    r = s & ~32'h0000_0122;
    r[8] = (p != rctu_pkg::PRIV_U);
    r[5] = s[1];
    return r;
  endfunction

  function automatic logic [31:0] m_return(input logic [31:0] s);
    logic [31:0] r;
    r = s & ~32'h0000_1888;
    r[3] = s[7];
    r[7] = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] s_return(input logic [31:0] s);
    logic [31:0] r;
    r = s & ~32'h0000_0122;
    r[1] = s[5];
    r[5] = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] vec_target(input logic [31:0] tvec, input logic intr,
                                             input logic [4:0] cause);
    logic [31:0] t;
    t = tvec & rctu_pkg::TVEC_BASE;
    if (intr && (tvec[1:0] == 2'd1)) begin
      t = t + {25'd0, cause, 2'b00};
    end
    return t;
  endfunction

  logic [4:0]  sel;
  logic [31:0] rd;
  logic [31:0] wv;
  logic        wr_en;

  // decode the address into the flop-held group or the plain memory
  always_comb begin
    unique case (csr_index)
      ADDR_BITS'(rctu_pkg::CSR_SSTATUS): sel = SEL_SSTATUS;
      ADDR_BITS'(rctu_pkg::CSR_MSTATUS): sel = SEL_MSTATUS;
      ADDR_BITS'(rctu_pkg::CSR_SIE):     sel = SEL_SIE;
      ADDR_BITS'(rctu_pkg::CSR_MIE):     sel = SEL_MIE;
      ADDR_BITS'(rctu_pkg::CSR_SIP):     sel = SEL_SIP;
      ADDR_BITS'(rctu_pkg::CSR_MIP):     sel = SEL_MIP;
      ADDR_BITS'(rctu_pkg::CSR_EXC_DELEG): sel = SEL_MEDELEG;
      ADDR_BITS'(rctu_pkg::CSR_MIDELEG): sel = SEL_MIDELEG;
      ADDR_BITS'(rctu_pkg::CSR_MTVEC):   sel = SEL_MTVEC;
      ADDR_BITS'(rctu_pkg::CSR_STVEC):   sel = SEL_STVEC;
      ADDR_BITS'(rctu_pkg::CSR_MEPC):    sel = SEL_MEPC;
      ADDR_BITS'(rctu_pkg::CSR_SEPC):    sel = SEL_SEPC;
      ADDR_BITS'(rctu_pkg::CSR_MCAUSE):  sel = SEL_MCAUSE;
      ADDR_BITS'(rctu_pkg::CSR_SCAUSE):  sel = SEL_SCAUSE;
      ADDR_BITS'(rctu_pkg::CSR_MTVAL):   sel = SEL_MTVAL;
      ADDR_BITS'(rctu_pkg::CSR_STVAL):   sel = SEL_STVAL;
      default:                           sel = SEL_RAM;
    endcase
  end

  always_comb begin
    unique case (sel)
      SEL_SSTATUS, SEL_MSTATUS: rd = st.status;
      SEL_SIE, SEL_MIE:         rd = st.ie;
      SEL_SIP, SEL_MIP:         rd = st.ip;
      SEL_MEDELEG:              rd = st.medeleg;
      SEL_MIDELEG:              rd = st.mideleg;
      SEL_MTVEC:                rd = st.mtvec;
      SEL_STVEC:                rd = st.stvec;
      SEL_MEPC:                 rd = st.mepc;
      SEL_SEPC:                 rd = st.sepc;
      SEL_MCAUSE:               rd = st.mcause;
      SEL_SCAUSE:               rd = st.scause;
      SEL_MTVAL:                rd = st.mtval;
      SEL_STVAL:                rd = st.stval;
      default:                  rd = ram_rdata;
    endcase
  end

  always_comb begin
    wr_en = 1'b1;
    case (item.write_op)
      rctu_pkg::OP_WRITE: wv = item.write_data;
      rctu_pkg::OP_SET:   wv = rd | item.write_data;
      rctu_pkg::OP_CLEAR: wv = rd & ~item.write_data;
      default: begin
        wv    = rd;
        wr_en = 1'b0;
      end
    endcase
  end

  // trap evaluation
  logic [1:0]  p;
  logic [31:0] pend;
  logic        mg, sg;
  logic        m_sw, m_ti, m_ex, s_sw, s_ti, s_ex;
  logic        m_intr, s_intr;
  logic        exc, to_s, use_tval;
  logic [4:0]  ecause, mcause_c, scause_c;

  always_comb begin
    p    = st.priv;
    pend = st.ip & st.ie;
    mg   = (p != rctu_pkg::PRIV_M) || st.status[3];
    sg   = (p == rctu_pkg::PRIV_U) || ((p == rctu_pkg::PRIV_S) && st.status[3]);
    m_sw = pend[3]  && !st.mideleg[3]  && mg;
    m_ti = pend[7]  && !st.mideleg[7]  && mg;
    m_ex = pend[11] && !st.mideleg[11] && mg;
    s_sw = ((pend[3]  && st.mideleg[3])  || pend[1]) && sg;
    s_ti = ((pend[7]  && st.mideleg[7])  || pend[5]) && sg;
    s_ex = ((pend[11] && st.mideleg[11]) || pend[9]) && sg;
    m_intr = m_sw || m_ti || m_ex;
    s_intr = s_sw || s_ti || s_ex;

    exc      = 1'b0;
    to_s     = 1'b0;
    use_tval = 1'b0;
    ecause   = 5'd0;
    unique case (item.event_code)
      rctu_pkg::EV_ECALL: begin
        exc = 1'b1;
        if (p == rctu_pkg::PRIV_U) begin
          ecause = 5'd8;
          to_s   = st.medeleg[8];
        end else if (p == rctu_pkg::PRIV_S) begin
          ecause = 5'd9;
          to_s   = st.medeleg[9];
        end else begin
          ecause = 5'd11;
        end
      end
      rctu_pkg::EV_INST_PF, rctu_pkg::EV_LOAD_PF, rctu_pkg::EV_STORE_PF: begin
        exc      = 1'b1;
        use_tval = 1'b1;
        if (item.event_code == rctu_pkg::EV_INST_PF) begin
          ecause = 5'd12;
        end else if (item.event_code == rctu_pkg::EV_LOAD_PF) begin
          ecause = 5'd13;
        end else begin
          ecause = 5'd15;
        end
        to_s = st.medeleg[ecause];
      end
      rctu_pkg::EV_ILLEGAL: begin
        exc      = 1'b1;
        use_tval = 1'b1;
        ecause   = 5'd2;
      end
      default: begin
        exc = 1'b0;
      end
    endcase

    mcause_c = m_sw ? 5'd3 : (m_ti ? 5'd7 : (m_ex ? 5'd11 : ecause));
    scause_c = s_ex ? 5'd9 : (s_ti ? 5'd5 : (s_sw ? 5'd1 : ecause));
  end

  always_comb begin
    st_nxt          = st;
    ram_wr.we       = 1'b0;
    ram_wr.data     = wv;
    result.read_data = rd;
    result.redirect  = rctu_pkg::REDIR_NONE;
    result.target_pc = 32'd0;

    if (item.kind == rctu_pkg::KIND_WRITE && wr_en) begin
      unique case (sel)
        SEL_SIE: st_nxt.ie = (st.ie & rctu_pkg::S_KEEP_MASK) | (wv & rctu_pkg::S_WRITE_MASK);
        SEL_MIE: st_nxt.ie = (st.ie & rctu_pkg::M_KEEP_MASK) | (wv & rctu_pkg::M_WRITE_MASK);
        SEL_SIP: st_nxt.ip = (st.ip & rctu_pkg::S_KEEP_MASK) | (wv & rctu_pkg::S_WRITE_MASK);
        SEL_MIP: st_nxt.ip = (st.ip & rctu_pkg::M_KEEP_MASK) | (wv & rctu_pkg::M_WRITE_MASK);
        SEL_SSTATUS:
          st_nxt.status = (st.status & rctu_pkg::SSTATUS_KEEP) | (wv & ~rctu_pkg::SSTATUS_KEEP);
        SEL_MSTATUS:
          st_nxt.status = (st.status & rctu_pkg::MSTATUS_KEEP) | (wv & ~rctu_pkg::MSTATUS_KEEP);
        SEL_MEDELEG: st_nxt.medeleg = wv;
        SEL_MIDELEG: st_nxt.mideleg = wv;
        SEL_MTVEC:   st_nxt.mtvec   = wv;
        SEL_STVEC:   st_nxt.stvec   = wv;
        SEL_MEPC:    st_nxt.mepc    = wv;
        SEL_SEPC:    st_nxt.sepc    = wv;
        SEL_MCAUSE:  st_nxt.mcause  = wv;
        SEL_SCAUSE:  st_nxt.scause  = wv;
        SEL_MTVAL:   st_nxt.mtval   = wv;
        SEL_STVAL:   st_nxt.stval   = wv;
        default:     ram_wr.we      = 1'b1;
      endcase
    end else if (item.kind == rctu_pkg::KIND_EVENT) begin
      if (m_intr || (exc && !to_s)) begin
        st_nxt.mepc      = item.pc;
        st_nxt.mcause    = {m_intr, 26'd0, mcause_c};
        st_nxt.mtval     = (!m_intr && use_tval) ? item.trap_value : 32'd0;
        st_nxt.status    = m_stack(st.status, p);
        st_nxt.priv      = rctu_pkg::PRIV_M;
        result.redirect  = rctu_pkg::REDIR_M_TRAP;
        result.target_pc = vec_target(st.mtvec, m_intr, mcause_c);
      end else if (s_intr || exc) begin
        st_nxt.sepc      = item.pc;
        st_nxt.scause    = {s_intr, 26'd0, scause_c};
        st_nxt.stval     = (!s_intr && use_tval) ? item.trap_value : 32'd0;
        st_nxt.status    = s_stack(st.status, p);
        st_nxt.priv      = rctu_pkg::PRIV_S;
        result.redirect  = rctu_pkg::REDIR_S_TRAP;
        result.target_pc = vec_target(st.stvec, s_intr, scause_c);
      end else if (item.event_code == rctu_pkg::EV_MRET) begin
        // reserved MPP drops to user mode
        st_nxt.priv      = (st.status[12:11] == rctu_pkg::PRIV_RS) ? rctu_pkg::PRIV_U
                                                                    : st.status[12:11];
        st_nxt.status    = m_return(st.status);
        result.redirect  = rctu_pkg::REDIR_MRET;
        result.target_pc = st.mepc;
      end else if (item.event_code == rctu_pkg::EV_SRET) begin
        st_nxt.priv      = {1'b0, st.status[8]};
        st_nxt.status    = s_return(st.status);
        result.redirect  = rctu_pkg::REDIR_SRET;
        result.target_pc = st.sepc;
      end
    end

    result.current_privilege = st_nxt.priv;
  end

endmodule

// File: rtl/riscv_csr_trap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_csr_trap_unit - machine/supervisor CSR file with trap handling
// Top level: clearing pass, input stage, CSR memory, state and result register.
// ----------------------------------------------------------------------------
// After reset the unit first clears its CSR memory, one entry per cycle, all
// 2**CSR_ADDR_BITS entries (4096 by default) with in_ready held low; misa is
// loaded with its reset value in that pass. From then on it takes one word per
// clock while the result register is not stalled. Acceptance launches the
// registered read of the CSR memory, and leaving the input stage commits the
// CSR update and loads the result register. The trap-relevant CSRs (status,
// ie, ip, delegation, tvec, epc, cause, tval) and the privilege level live in
// flip-flops; every other address is a plain entry of the memory. A write to
// the memory in the commit cycle is forwarded to a read launched in the same
// edge, so back-to-back accesses to one address see each other in order.
// A stalled result register stalls the input stage and then in_ready.
// ----------------------------------------------------------------------------
module riscv_csr_trap_unit #(
  parameter int CSR_ADDR_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  rctu_in_if.sink    in_ch,
  rctu_out_if.source out_ch
);

  localparam int CSR_DEPTH = 1 << CSR_ADDR_BITS;

  // clearing pass: the top bit of the counter marks it done
  logic [CSR_ADDR_BITS:0] clr_cnt_r;
  logic                   clr_done;

  // input stage
  logic                     s1_valid_r;
  logic [CSR_ADDR_BITS-1:0] s1_index_r;
  rctu_pkg::item_t          s1_item_r;
  logic                     byp_hit_r;
  logic [31:0]              byp_data_r;

  // architectural state and result register
  rctu_pkg::csr_state_t state_r;
  rctu_pkg::csr_state_t state_nxt;
  logic                 out_valid_r;
  rctu_pkg::result_t    out_r;
  rctu_pkg::result_t    result;

  // memory ports
  rctu_pkg::ram_wr_t        exec_wr;
  logic                     ram_we;
  logic [CSR_ADDR_BITS-1:0] ram_waddr;
  logic [31:0]              ram_wdata;
  logic [31:0]              ram_rdata;
  logic [31:0]              rd_word;

  logic accept;
  logic s1_adv;

  assign clr_done = clr_cnt_r[CSR_ADDR_BITS];

  // advance the input stage whenever the result register is free or drains
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = clr_done && (!s1_valid_r || s1_adv);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // write port: clearing pass first, then commits of plain entries
  always_comb begin
    if (!clr_done) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r[CSR_ADDR_BITS-1:0];
      ram_wdata = (clr_cnt_r[CSR_ADDR_BITS-1:0] == CSR_ADDR_BITS'(rctu_pkg::CSR_MISA))
                  ? rctu_pkg::MISA_RESET : 32'd0;
    end else begin
      ram_we    = s1_adv && exec_wr.we;
      ram_waddr = s1_index_r;
      ram_wdata = exec_wr.data;
    end
  end

  rctu_ram #(
    .WIDTH (32),
    .DEPTH (CSR_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr   (in_ch.csr_index),
    .rdata_r (ram_rdata)
  );

  // capture the word and note a same-edge write to the address being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_index_r            <= in_ch.csr_index;
      s1_item_r.kind        <= in_ch.kind;
      s1_item_r.write_op    <= in_ch.write_op;
      s1_item_r.write_data  <= in_ch.write_data;
      s1_item_r.event_code  <= in_ch.event_code;
      s1_item_r.pc          <= in_ch.pc;
      s1_item_r.trap_value  <= in_ch.trap_value;
      byp_hit_r             <= ram_we && (ram_waddr == in_ch.csr_index);
      byp_data_r            <= ram_wdata;
    end
  end

  assign rd_word = byp_hit_r ? byp_data_r : ram_rdata;

  rctu_exec #(
    .ADDR_BITS (CSR_ADDR_BITS)
  ) u_exec (
    .csr_index (s1_index_r),
    .item      (s1_item_r),
    .st        (state_r),
    .ram_rdata (rd_word),
    .st_nxt    (state_nxt),
    .ram_wr    (exec_wr),
    .result    (result)
  );

  // commit the CSR update as the word leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{priv: rctu_pkg::PRIV_M, default: '0};
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.read_data         = out_r.read_data;
  assign out_ch.redirect          = out_r.redirect;
  assign out_ch.target_pc         = out_r.target_pc;
  assign out_ch.current_privilege = out_r.current_privilege;

`ifndef SYNTHESIS
  // no word may enter or sit in the input stage while the memory is cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> (!in_ch.ready && !s1_valid_r))
    else $error("word taken during clearing pass");

  // a result without a redirect carries no target
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.redirect == rctu_pkg::REDIR_NONE)) |-> (out_ch.target_pc == 32'd0))
    else $error("target without redirect");

  // the reserved privilege level is never entered
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.priv != rctu_pkg::PRIV_RS)
    else $error("reserved privilege level reached");

  // an M trap result leaves the unit in machine mode
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.redirect == rctu_pkg::REDIR_M_TRAP))
      |-> (out_ch.current_privilege == rctu_pkg::PRIV_M))
    else $error("M trap without machine mode");
`endif

endmodule
